>>> hw/rtl/rpn_pkg.sv
// Shared constants, codes and types of the RPN stack calculator.
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

   localparam int WORD_W      = 32;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int STACK_DEPTH = 15;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_VALUE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

   // characters
   localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/rpn_if.sv
// Valid/ready channel interfaces for characters in and results out.
`timescale 1ns / 1ps
`default_nettype none

interface rpn_req_if import rpn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_alu.sv
// Iterative ALU: one 33-bit adder shared by add, sub, shift-add multiply, restoring divide.
`timescale 1ns / 1ps
`default_nettype none

module rpn_alu import rpn_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire alu_ctl_type       ctl,
   input  wire logic [WORD_W-1:0] a,
   input  wire logic [WORD_W-1:0] b,
   output logic                   done,
   output logic      [WORD_W-1:0] result
);

   localparam int CNT_W = $clog2(WORD_W);

   typedef enum logic [5:0] {
      A_IDLE   = 6'b000001,
      A_ADDSUB = 6'b000010,
      A_NEG_A  = 6'b000100,
      A_NEG_B  = 6'b001000,
      A_LOOP   = 6'b010000,
      A_FIX    = 6'b100000
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] x_ff, x_in;     // multiplicand / divisor
   logic [WORD_W-1:0] y_ff, y_in;     // multiplier / dividend, then quotient
   logic [WORD_W-1:0] acc_ff, acc_in; // product / remainder

   logic [WORD_W:0]   add_p, add_q, sum;
   logic              add_cin;
   logic [WORD_W-1:0] rem_sh;
   logic              ge;

   // shared adder
   assign sum    = add_p + add_q + {{WORD_W{1'b0}}, add_cin};
   assign rem_sh = {acc_ff[WORD_W-2:0], y_ff[WORD_W-1]};
   assign ge     = ~sum[WORD_W];

   always_comb begin
      add_p   = '0;
      add_q   = '0;
      add_cin = 1'b0;
      case (state_ff)
         A_ADDSUB: begin
            add_p   = {1'b0, y_ff};
            add_q   = {1'b0, (op_ff == OP_SUB) ? ~x_ff : x_ff};
            add_cin = (op_ff == OP_SUB);
         end
         A_NEG_A: begin
            add_q   = {1'b0, ~y_ff};
            add_cin = 1'b1;
         end
         A_NEG_B: begin
            add_q   = {1'b0, ~x_ff};
            add_cin = 1'b1;
         end
         A_LOOP: begin
            if (op_ff == OP_MUL) begin
               add_p = {1'b0, acc_ff};
               add_q = {1'b0, x_ff};
            end else begin
               add_p   = {1'b0, rem_sh};
               add_q   = ~{1'b0, x_ff};
               add_cin = 1'b1;
            end
         end
         A_FIX: begin
            add_q   = {1'b0, ~y_ff};
            add_cin = 1'b1;
         end
         default: begin
            add_p = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      case (state_ff)
         A_IDLE: begin
            if (ctl.start) begin
               op_in  = ctl.op;
               neg_in = a[WORD_W-1] ^ b[WORD_W-1];
               cnt_in = '0;
               x_in   = b;
               y_in   = a;
               acc_in = '0;
               case (ctl.op)
                  OP_ADD, OP_SUB: state_in = A_ADDSUB;
                  OP_MUL:         state_in = A_LOOP;
                  default:        state_in = A_NEG_A;
               endcase
            end
         end
         A_ADDSUB: begin
            y_in     = sum[WORD_W-1:0];
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         A_NEG_A: begin
            if (y_ff[WORD_W-1]) begin
               y_in = sum[WORD_W-1:0];
            end
            state_in = A_NEG_B;
         end
         A_NEG_B: begin
            if (x_ff[WORD_W-1]) begin
               x_in = sum[WORD_W-1:0];
            end
            state_in = A_LOOP;
         end
         A_LOOP: begin
            if (op_ff == OP_MUL) begin
               if (y_ff[0]) begin
                  acc_in = sum[WORD_W-1:0];
               end
               x_in = {x_ff[WORD_W-2:0], 1'b0};
               y_in = {1'b0, y_ff[WORD_W-1:1]};
            end else begin
               acc_in = ge ? sum[WORD_W-1:0] : rem_sh;
               y_in   = {y_ff[WORD_W-2:0], ge};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               if (op_ff == OP_MUL) begin
                  done_in  = 1'b1;
                  state_in = A_IDLE;
               end else begin
                  state_in = A_FIX;
               end
            end
         end
         A_FIX: begin
            if (neg_ff) begin
               y_in = sum[WORD_W-1:0];
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_MUL) ? acc_ff : y_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: sequencer, operand stack and result register.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates a Reverse Polish expression one ASCII character per transfer on a stack of
// 15 signed 32-bit words (wrapping arithmetic, division truncates toward zero). Digits push,
// + - * / combine the top two entries, = pops the top into a result transfer, newline clears
// the stack, everything else is ignored. Overflow, underflow and divide by zero produce a
// result with value 0 and an error status and clear the stack. The block takes one character
// at a time; req ready drops while a character is worked on. A divide by zero is seen only
// after both operands are read. Multiply and divide walk 32 bits through the shared adder of
// the ALU, one bit a cycle, and divide adds sign fix-up steps around that. Each operator reads
// its two operands out of the single-read-port stack RAM one after the other, the right one
// read from S_IDLE and the left one from S_RDR. A result waits in the output register while
// the next characters are taken; only a character that must produce a result while the
// previous one is still untaken waits for rsp ready.
module rpn_stack_calculator import rpn_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   rpn_req_if.sink   req_chan,
   rpn_rsp_if.source rsp_chan
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, // take a character
      S_RDEQ = 6'b000010, // stack read for '=' in flight
      S_RDR  = 6'b000100, // right operand arriving, read left
      S_RDL  = 6'b001000, // left operand arriving, start ALU or flag divide by zero
      S_BUSY = 6'b010000, // wait for ALU, push result
      S_EMIT = 6'b100000  // hand pending result to output register
   } state_type;

   state_type            state_ff, state_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   alu_op_type           op_ff, op_in;
   logic [WORD_W-1:0]    r_ff, r_in;
   logic [WORD_W-1:0]    pend_value_ff, pend_value_in;
   logic [STATUS_W-1:0]  pend_status_ff, pend_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // stack RAM port
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_W-1:0]    rd_data;

   // ALU
   alu_ctl_type          alu_ctl;
   logic                 alu_done;
   logic [WORD_W-1:0]    alu_result;

   logic                 accept;
   logic                 slot_free;
   logic [CHAR_W-1:0]    ch;

   assign accept    = req_chan.valid & req_chan.ready;
   assign slot_free = ~rsp_valid_ff | rsp_chan.ready;
   assign ch        = req_chan.char_code;

   rpn_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpn_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (rd_data),
      .b      (r_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in       = state_ff;
      depth_in       = depth_ff;
      op_in          = op_ff;
      r_in           = r_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(depth_ff);
      wr_data        = alu_result;
      rd_en          = 1'b0;
      rd_addr        = ADDR_W'(depth_ff - DEPTH_W'(1)); // top of stack
      alu_ctl.start  = 1'b0;
      alu_ctl.op     = op_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_value_in = '0;
               if (ch inside {[CH_0:CH_9]}) begin
                  if (depth_ff == DEPTH_W'(STACK_DEPTH)) begin
                     pend_status_in = ST_OVERFLOW;
                     depth_in       = '0;
                     state_in       = S_EMIT;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = {{(WORD_W - 4){1'b0}}, ch[3:0]};
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
               end else if (ch == CH_LF) begin
                  depth_in = '0;
               end else if (ch == CH_EQ) begin
                  if (depth_ff == '0) begin
                     pend_status_in = ST_UNDERFLOW;
                     state_in       = S_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     depth_in = depth_ff - DEPTH_W'(1);
                     state_in = S_RDEQ;
                  end
               end else if (ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
                  case (ch)
                     CH_PLUS:  op_in = OP_ADD;
                     CH_MINUS: op_in = OP_SUB;
                     CH_STAR:  op_in = OP_MUL;
                     default:  op_in = OP_DIV;
                  endcase
                  if (depth_ff < DEPTH_W'(2)) begin
                     pend_status_in = ST_UNDERFLOW;
                     depth_in       = '0;
                     state_in       = S_EMIT;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_RDR;
                  end
               end
               // space and anything else: no effect
            end
         end
         S_RDEQ: begin
            pend_value_in  = rd_data;
            pend_status_in = ST_VALUE;
            state_in       = S_EMIT;
         end
         S_RDR: begin
            r_in     = rd_data;
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(depth_ff - DEPTH_W'(2));
            state_in = S_RDL;
         end
         S_RDL: begin
            if (op_ff == OP_DIV && r_ff == '0) begin
               pend_value_in  = '0;
               pend_status_in = ST_DIVZERO;
               depth_in       = '0;
               state_in       = S_EMIT;
            end else begin
               alu_ctl.start = 1'b1;
               depth_in      = depth_ff - DEPTH_W'(2);
               state_in      = S_BUSY;
            end
         end
         S_BUSY: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               depth_in = depth_ff + DEPTH_W'(1);
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      r_ff           <= r_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_checker.sv
// Port-level assertions for the RPN stack calculator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rpn_checker import rpn_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic [CHAR_W-1:0]   req_char_code,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [WORD_W-1:0]   rsp_value,
   input wire logic [STATUS_W-1:0] rsp_status
);

   logic req_xfer;
   logic busy_char;

   assign req_xfer  = req_valid & req_ready;
   assign busy_char = (req_char_code == CH_EQ) || (req_char_code == CH_PLUS) ||
                      (req_char_code == CH_MINUS) || (req_char_code == CH_STAR) ||
                      (req_char_code == CH_SLASH);

   // a result stays offered until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_VALUE |-> rsp_value == '0)
      else $error("error result with nonzero value");

   // no result is offered right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // '=' and operators keep the block busy in the following cycle
   a_busy_after_op: assert property (@(posedge clock) disable iff (reset)
      req_xfer && busy_char |=> !req_ready)
      else $error("ready right after an operator transfer");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_char_code (req_chan.char_code),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_value     (rsp_chan.value),
   .rsp_status    (rsp_chan.status)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the RPN stack calculator: streams characters and checks results.
`timescale 1ns / 1ps

module testbench;
   import rpn_pkg::*;

   // Run length and limits.
   localparam int ITEM_TARGET     = 1300;   // characters sent, every code counted
   localparam int HOLD_OFF_CYCLES = 400;    // one long receiver stall
   localparam int DRAIN_CYCLES    = 60;     // settle time after the last result
   localparam int CYCLE_LIMIT     = 500000;

   // One result transfer as the block presents it.
   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } calc_result_type;

   // ------------------------------------------------------------------
   // Expression tracker: keeps its own operand stack, works out the
   // result (if any) of every accepted character and checks the block's
   // result transfers against them in order.
   // ------------------------------------------------------------------
   class rpn_expr_checker;
      logic [WORD_W-1:0] stack_words[STACK_DEPTH];
      int                depth;
      calc_result_type   expected_results[$];
      int                mismatches;
      int                results_checked;
      int                status_count[4];

      function new();
         depth           = 0;
         mismatches      = 0;
         results_checked = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
      endfunction

      // Error results always carry value 0 and empty the stack.
      function void add_error(logic [STATUS_W-1:0] st);
         calc_result_type r;
         depth    = 0;
         r.value  = '0;
         r.status = st;
         expected_results.push_back(r);
         status_count[st]++;
      endfunction

      // Called for every character transfer into the block.
      function void note_char(logic [CHAR_W-1:0] c);
         logic [WORD_W-1:0] lhs, rhs, res, lhs_mag, rhs_mag, quot;
         calc_result_type   r;
         if (c >= CH_0 && c <= CH_9) begin
            if (depth >= STACK_DEPTH) begin
               add_error(ST_OVERFLOW);
            end else begin
               stack_words[depth] = WORD_W'(c - CH_0);
               depth++;
            end
         end else if (c == CH_LF) begin
            depth = 0;
         end else if (c == CH_EQ) begin
            if (depth == 0) begin
               add_error(ST_UNDERFLOW);
            end else begin
               depth--;
               r.value  = stack_words[depth];
               r.status = ST_VALUE;
               expected_results.push_back(r);
               status_count[ST_VALUE]++;
            end
         end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
            if (depth < 2) begin
               add_error(ST_UNDERFLOW);
            end else begin
               rhs   = stack_words[depth - 1];
               lhs   = stack_words[depth - 2];
               depth = depth - 2;
               case (c)
                  CH_PLUS:  res = lhs + rhs;
                  CH_MINUS: res = lhs - rhs;
                  CH_STAR:  res = lhs * rhs;   // low 32 bits of the product
                  default: begin
                     if (rhs == '0) begin
                        add_error(ST_DIVZERO);
                        return;
                     end
                     // divide magnitudes, then fix the sign: truncates toward
                     // zero and wraps most-negative / -1 back to itself
                     lhs_mag = lhs[WORD_W-1] ? -lhs : lhs;
                     rhs_mag = rhs[WORD_W-1] ? -rhs : rhs;
                     quot    = lhs_mag / rhs_mag;
                     res     = (lhs[WORD_W-1] != rhs[WORD_W-1]) ? -quot : quot;
                  end
               endcase
               stack_words[depth] = res;
               depth++;
            end
         end
         // space and every other code: no effect
      endfunction

      // Called for every result transfer out of the block.
      function void check_result(logic signed [WORD_W-1:0] value, logic [STATUS_W-1:0] status);
         calc_result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result: value %0d status %0d", value, status));
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (value !== want.value)
            report($sformatf("result %0d value: expected %0d, got %0d",
                             results_checked, want.value, value));
         if (status !== want.status)
            report($sformatf("result %0d status: expected %0d, got %0d",
                             results_checked, want.status, status));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   initial forever #5 clock = ~clock;

   rpn_req_if req_if();
   rpn_rsp_if rsp_if();

   rpn_stack_calculator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   rpn_expr_checker expr_checker;

   int  cycle_count   = 0;
   int  burst_left    = 0;
   int  chars_offered = 0;
   int  items_sent    = 0;    // characters other than space and unknown codes
   bit  hold_off_req  = 1'b0;

   // Monitor: both channels are sampled at the rising edge. The result is
   // checked before the character of the same edge is noted, since a result
   // leaving at this edge always belongs to an earlier character.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            expr_checker.check_result(rsp_if.value, rsp_if.status);
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            expr_checker.note_char(req_if.char_code);
      end
   end

   // Watchdog: ends a run that hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expr_checker.pending());
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: ready changes at the falling edge. It switches between
   // patterns (always ready, coin flip, mostly stalled, toggling) and, once
   // asked, holds off for a long stretch so the single result register stays
   // full and the block has to stall its character input.
   initial begin : receiver
      int mode;
      int mode_left;
      bit hold_done;
      mode      = 0;
      mode_left = 0;
      hold_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
               default: rsp_if.ready <= mode_left[0];
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side. Every task starts and ends at a falling edge.
   // ------------------------------------------------------------------

   // One character transfer. Characters go out in bursts of random length;
   // between bursts valid drops for a random gap (sometimes none at all).
   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.char_code <= c;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
      chars_offered++;
      if ((c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
          c == CH_SLASH || c == CH_EQ || c == CH_LF)
         items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // Well-formed expression, sometimes after a newline that empties the stack: random digits and
   // operators (multiply favored to reach wide values), stray spaces,
   // reduced to one entry and popped with '='.
   task automatic gen_expression();
      int operands;
      int pushed;
      int level;
      int pick;
      operands = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
      pushed   = 0;
      level    = 0;
      if ($urandom_range(0, 3) == 0) send_char(CH_LF);
      while (pushed < operands || level > 1) begin
         if (pushed < operands && (level < 2 || $urandom_range(0, 2) == 0)) begin
            send_char(CH_0 + CHAR_W'($urandom_range(0, 9)));
            pushed++;
            level++;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 4)      send_char(CH_STAR);
            else if (pick < 6) send_char(CH_PLUS);
            else if (pick < 8) send_char(CH_MINUS);
            else               send_char(CH_SLASH);
            level--;
         end
         if ($urandom_range(0, 7) == 0) send_char(CH_SPACE);
      end
      send_char(CH_EQ);
   endtask

   // Fill the stack to its depth or past it; finish with an optional pop and a clear.
   task automatic gen_overflow_run();
      int n;
      n = STACK_DEPTH + $urandom_range(0, 3);
      send_char(CH_LF);
      repeat (n) send_char(CH_0 + CHAR_W'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 1) send_char(CH_EQ);
      send_char(CH_LF);
   endtask

   // Build 2^31 (the most negative word), divide by -1, pop.
   task automatic gen_min_div_minus_one();
      send_text("88*8*8*8*8*8*8*8*8*2*01-/=");
   endtask

   // Valid characters in random order, with no regard for stack depth.
   task automatic gen_broken();
      int n;
      int pick;
      n = $urandom_range(1, 10);
      repeat (n) begin
         pick = $urandom_range(0, 15);
         case (pick)
            10:      send_char(CH_PLUS);
            11:      send_char(CH_MINUS);
            12:      send_char(CH_STAR);
            13:      send_char(CH_SLASH);
            14:      send_char(CH_EQ);
            15:      send_char(CH_LF);
            default: send_char(CH_0 + CHAR_W'(pick));
         endcase
      end
      if ($urandom_range(0, 1) == 1) send_char(CH_LF);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main
      int pick;
      expr_checker = new();
      reset = 1'b1;
      req_if.valid     <= 1'b0;
      req_if.char_code <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: pop from empty, operator on one entry, divide by zero,
      // every operator with digits 0 and 9, truncating negative divide,
      // ignored codes, and a newline that empties the stack before a pop.
      send_char(CH_EQ);
      send_text("3+");
      send_text("50/");
      send_text("95-78*+=");
      send_text("07-2/=");
      send_char(CH_SPACE);
      send_char(8'hFF);
      send_char(8'h00);
      send_text("12");
      send_char(CH_LF);
      send_char(CH_EQ);

      // Random part. The long receiver stall starts right away while the
      // sender keeps going.
      hold_off_req = 1'b1;
      gen_overflow_run();
      gen_min_div_minus_one();
      while (chars_offered < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 67) begin
            gen_expression();
         end else if (pick < 75) begin
            gen_overflow_run();
         end else if (pick < 85) begin
            gen_broken();
         end else if (pick < 95) begin
            // noise: any code at all, digits and operators included
            repeat ($urandom_range(1, 6)) send_char(CHAR_W'($urandom_range(0, 255)));
         end else begin
            gen_min_div_minus_one();
         end
      end
      req_if.valid <= 1'b0;

      // Drain: wait for every expected result, then let the block settle.
      while (expr_checker.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters (%0d acting on the stack); %0d results checked.",
               chars_offered, items_sent, expr_checker.results_checked);
      $display("Results: %0d values, %0d overflow, %0d underflow, %0d divide by zero.",
               expr_checker.status_count[ST_VALUE], expr_checker.status_count[ST_OVERFLOW],
               expr_checker.status_count[ST_UNDERFLOW], expr_checker.status_count[ST_DIVZERO]);
      if (expr_checker.mismatches == 0 && expr_checker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", expr_checker.mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
